[src/stepper_homing_sequencer_unit_defines.svh]
// assertion macros for the stepper homing sequencer
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef STEPPER_HOMING_SEQUENCER_UNIT_DEFINES_SVH
`define STEPPER_HOMING_SEQUENCER_UNIT_DEFINES_SVH

// condition must hold at every edge out of reset
`define SHS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold on the edge after the antecedent
`define SHS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/shs_pkg.sv]
// types and codes of the stepper homing sequencer
// no dependencies
package shs_pkg;

    // sequencer phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_FAST = 4'b0010,
        PH_BACK = 4'b0100,
        PH_SLOW = 4'b1000
    } t_phase;

    // status codes
    localparam logic [2:0] ST_NEVER     = 3'd0;
    localparam logic [2:0] ST_RUNNING   = 3'd1;
    localparam logic [2:0] ST_HOMED     = 3'd2;
    localparam logic [2:0] ST_FAST_FAIL = 3'd3;
    localparam logic [2:0] ST_SLOW_FAIL = 3'd4;

    // configuration register indexes
    localparam logic [2:0] CFG_FAST_HALF = 3'd0;
    localparam logic [2:0] CFG_SLOW_HALF = 3'd1;
    localparam logic [2:0] CFG_TRAVEL    = 3'd2;
    localparam logic [2:0] CFG_BACKOFF   = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE  = 3'd4;
    localparam logic [2:0] CFG_HOME_DIR  = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 20;

    // reset values of the configuration registers
    localparam logic [15:0] RST_FAST_HALF = 16'd312;
    localparam logic [15:0] RST_SLOW_HALF = 16'd625;
    localparam logic [19:0] RST_TRAVEL    = 20'd96000;
    localparam logic [15:0] RST_BACKOFF   = 16'd1600;
    localparam logic [15:0] RST_DEBOUNCE  = 16'd10000;
    localparam logic        RST_HOME_DIR  = 1'b1;

    localparam logic [15:0] SINCE_MAX = 16'hFFFF;

endpackage

[src/stepper_homing_sequencer_unit.sv]
// stepper homing sequencer, top level
// depends on shs_pkg and stepper_homing_sequencer_unit_defines.svh
//
// Usage: each input item is one microsecond tick carrying a start request and
// the sampled limit switch level (0 = pressed). Each accepted item yields
// exactly one result item with the step pin level, the direction pin level and
// the status (never run, running, homed, fast failed, slow failed).
// Channels: input i_in_valid/o_in_ready, result o_out_valid/i_out_ready,
// configuration i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data.
// o_cfg_ready is always high; unknown indexes are ignored. Write registers only
// while the block is idle.
// The result of an item is registered in the output or the skid register.
// Throughput: one item per cycle while o_in_ready is high; the whole tick
// update is a single pass of logic from the state registers into the buffer.
// A two-entry result buffer (output register plus skid register) lets one
// more item in while a result waits; o_in_ready drops only when both hold.
// Reset (synchronous, active low) puts the sequencer idle, the press counter
// saturated, the buffer empty and the registers at their defaults.
`include "stepper_homing_sequencer_unit_defines.svh"

module stepper_homing_sequencer_unit #(
    parameter int COUNT_WIDTH = 20,
    parameter int TIMER_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_start_req,
    input  logic                               i_switch_level,
    // result items
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_step_out,
    output logic                               o_dir_out,
    output logic [2:0]                         o_status,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [shs_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [shs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [32:0] COUNT_MAX33 = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam logic [32:0] TIMER_MAX33 = (33'd1 << TIMER_WIDTH) - 33'd1;

    // configuration registers
    logic [15:0] r_fast_half;
    logic [15:0] r_slow_half;
    logic [19:0] r_travel;
    logic [15:0] r_backoff;
    logic [15:0] r_debounce;
    logic        r_home_dir;

    // sequencer state
    shs_pkg::t_phase          r_phase,  n_phase;
    logic [COUNT_WIDTH-1:0]   r_pulses, n_pulses;
    logic [TIMER_WIDTH-1:0]   r_half_timer, n_half_timer;
    logic                     r_pulse_high, n_pulse_high;
    logic                     r_pressed, n_pressed;
    logic [15:0]              r_since, n_since;
    logic                     r_prev_sw, n_prev_sw;
    logic [2:0]               r_status, n_status;
    logic                     r_dir, n_dir;

    // result buffer
    logic       r_out_valid;
    logic       r_skid_valid;
    logic       r_out_step, r_out_dir;
    logic [2:0] r_out_status;
    logic       r_skid_step, r_skid_dir;
    logic [2:0] r_skid_status;

    logic in_take;
    logic out_take;

    // saturated half periods and pulse limits
    logic [32:0]            fast_hp33, slow_hp33, travel33, backoff33;
    logic [TIMER_WIDTH-1:0] fast_len, slow_len;
    logic [COUNT_WIDTH-1:0] travel_lim, backoff_lim;

    logic                   c_fresh;
    logic                   c_check;
    logic                   c_stop;
    logic [COUNT_WIDTH-1:0] c_lim;

    assign fast_hp33 = (r_fast_half == 16'd0) ? 33'd1 : 33'(r_fast_half);
    assign slow_hp33 = (r_slow_half == 16'd0) ? 33'd1 : 33'(r_slow_half);
    assign travel33  = 33'(r_travel);
    assign backoff33 = 33'(r_backoff);

    assign fast_len    = (fast_hp33 > TIMER_MAX33) ? '1 : fast_hp33[TIMER_WIDTH-1:0];
    assign slow_len    = (slow_hp33 > TIMER_MAX33) ? '1 : slow_hp33[TIMER_WIDTH-1:0];
    assign travel_lim  = (travel33 > COUNT_MAX33) ? '1 : travel33[COUNT_WIDTH-1:0];
    assign backoff_lim = (backoff33 > COUNT_MAX33) ? '1 : backoff33[COUNT_WIDTH-1:0];

    // one tick of the homing sequence
    always_comb begin
        n_phase      = r_phase;
        n_pulses     = r_pulses;
        n_half_timer = r_half_timer;
        n_pulse_high = r_pulse_high;
        n_pressed    = r_pressed;
        n_since      = r_since;
        n_prev_sw    = i_switch_level;
        n_status     = r_status;
        n_dir        = r_dir;
        c_fresh      = 1'b0;
        c_check      = 1'b0;
        c_stop       = 1'b0;
        c_lim        = '0;

        if (n_phase == shs_pkg::PH_IDLE && i_start_req) begin
            n_phase      = shs_pkg::PH_FAST;
            n_dir        = r_home_dir;
            n_pulses     = '0;
            n_half_timer = '0;
            n_pulse_high = 1'b0;
            n_pressed    = 1'b0;
            n_status     = shs_pkg::ST_RUNNING;
            c_fresh      = 1'b1;
        end

        if (n_since != shs_pkg::SINCE_MAX) begin
            n_since = n_since + 16'd1;
        end
        // falling edge counts as a press only outside the debounce window
        if (n_phase != shs_pkg::PH_IDLE && r_prev_sw && !i_switch_level) begin
            if (n_since == shs_pkg::SINCE_MAX || n_since > r_debounce) begin
                n_pressed = 1'b1;
                n_since   = 16'd0;
            end
        end

        if (n_phase != shs_pkg::PH_IDLE) begin
            c_check = c_fresh;
            if (!c_fresh) begin
                if (n_half_timer != '0) begin
                    n_half_timer = n_half_timer - TIMER_WIDTH'(1);
                end
                if (n_half_timer == '0) begin
                    if (n_pulse_high) begin
                        n_pulse_high = 1'b0;
                        n_half_timer = (n_phase == shs_pkg::PH_FAST) ? fast_len : slow_len;
                    end else begin
                        if (n_pulses != COUNT_MAX) begin
                            n_pulses = n_pulses + COUNT_WIDTH'(1);
                        end
                        c_check = 1'b1;
                    end
                end
            end

            // check point: a phase can end at once and hand over to the next
            if (c_check) begin
                for (int g = 0; g < 4; g++) begin
                    if (!c_stop && n_phase != shs_pkg::PH_IDLE) begin
                        c_lim = (n_phase == shs_pkg::PH_FAST) ? travel_lim : backoff_lim;
                        if (!n_pressed && n_pulses < c_lim) begin
                            n_pulse_high = 1'b1;
                            n_half_timer = (n_phase == shs_pkg::PH_FAST) ? fast_len : slow_len;
                            c_stop       = 1'b1;
                        end else begin
                            case (n_phase)
                                shs_pkg::PH_FAST: begin
                                    if (n_pressed) begin
                                        n_pressed = 1'b0;
                                        n_phase   = shs_pkg::PH_BACK;
                                        n_dir     = ~r_home_dir;
                                        n_pulses  = '0;
                                    end else begin
                                        n_status = shs_pkg::ST_FAST_FAIL;
                                        n_phase  = shs_pkg::PH_IDLE;
                                    end
                                end
                                shs_pkg::PH_BACK: begin
                                    n_phase  = shs_pkg::PH_SLOW;
                                    n_dir    = r_home_dir;
                                    n_pulses = '0;
                                end
                                shs_pkg::PH_SLOW: begin
                                    n_status = n_pressed ? shs_pkg::ST_HOMED
                                                         : shs_pkg::ST_SLOW_FAIL;
                                    n_phase  = shs_pkg::PH_IDLE;
                                end
                                default: begin
                                    n_phase = shs_pkg::PH_IDLE;
                                end
                            endcase
                        end
                    end
                end
            end
        end

        if (n_phase == shs_pkg::PH_IDLE) begin
            n_pulse_high = 1'b0;
            n_half_timer = '0;
        end
    end

    assign o_in_ready  = ~r_skid_valid;
    assign in_take     = i_in_valid & o_in_ready;
    assign out_take    = r_out_valid & i_out_ready;
    assign o_cfg_ready = 1'b1;

    // configuration and sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_half  <= shs_pkg::RST_FAST_HALF;
            r_slow_half  <= shs_pkg::RST_SLOW_HALF;
            r_travel     <= shs_pkg::RST_TRAVEL;
            r_backoff    <= shs_pkg::RST_BACKOFF;
            r_debounce   <= shs_pkg::RST_DEBOUNCE;
            r_home_dir   <= shs_pkg::RST_HOME_DIR;
            r_phase      <= shs_pkg::PH_IDLE;
            r_pulses     <= '0;
            r_half_timer <= '0;
            r_pulse_high <= 1'b0;
            r_pressed    <= 1'b0;
            r_since      <= shs_pkg::SINCE_MAX;
            r_prev_sw    <= 1'b1;
            r_status     <= shs_pkg::ST_NEVER;
            r_dir        <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    shs_pkg::CFG_FAST_HALF: r_fast_half <= i_cfg_data[15:0];
                    shs_pkg::CFG_SLOW_HALF: r_slow_half <= i_cfg_data[15:0];
                    shs_pkg::CFG_TRAVEL:    r_travel    <= i_cfg_data[19:0];
                    shs_pkg::CFG_BACKOFF:   r_backoff   <= i_cfg_data[15:0];
                    shs_pkg::CFG_DEBOUNCE:  r_debounce  <= i_cfg_data[15:0];
                    shs_pkg::CFG_HOME_DIR:  r_home_dir  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (in_take) begin
                r_phase      <= n_phase;
                r_pulses     <= n_pulses;
                r_half_timer <= n_half_timer;
                r_pulse_high <= n_pulse_high;
                r_pressed    <= n_pressed;
                r_since      <= n_since;
                r_prev_sw    <= n_prev_sw;
                r_status     <= n_status;
                r_dir        <= n_dir;
            end
        end
    end

    // result buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_take) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= in_take;
                end
            end else if (in_take) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    // result buffer payload
    always_ff @(posedge i_clk) begin
        if (out_take && r_skid_valid) begin
            r_out_step   <= r_skid_step;
            r_out_dir    <= r_skid_dir;
            r_out_status <= r_skid_status;
        end else if (in_take && (out_take || !r_out_valid)) begin
            r_out_step   <= n_pulse_high;
            r_out_dir    <= n_dir;
            r_out_status <= n_status;
        end
        if (in_take && r_out_valid && !out_take) begin
            r_skid_step   <= n_pulse_high;
            r_skid_dir    <= n_dir;
            r_skid_status <= n_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_step_out  = r_out_step;
    assign o_dir_out   = r_out_dir;
    assign o_status    = r_out_status;

    `SHS_ASSERT_ALWAYS(a_skid_needs_out, !r_skid_valid || r_out_valid, "skid holds item with output empty")
    `SHS_ASSERT_ALWAYS(a_idle_step_low, r_phase != shs_pkg::PH_IDLE || !r_pulse_high, "step high while idle")
    `SHS_ASSERT_ALWAYS(a_high_has_time, !r_pulse_high || r_half_timer != '0, "step high with expired timer")
    `SHS_ASSERT_ALWAYS(a_status_running, (r_phase == shs_pkg::PH_IDLE) == (r_status != shs_pkg::ST_RUNNING), "status and phase disagree")
    `SHS_ASSERT_NEXT(a_full_blocks_input, r_skid_valid && !i_out_ready, !o_in_ready, "input taken with full buffer")

endmodule

[bench/tb_stepper_homing_sequencer_unit.sv]
// testbench of the stepper homing sequencer: ticks go in one item per handshake,
// each result is checked against a cycle-accurate prediction of the homing cycle
// depends on shs_pkg and stepper_homing_sequencer_unit
module tb_stepper_homing_sequencer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       step;
        logic       dir;
        logic [2:0] status;
    } t_pins;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic                            i_start_req = 1'b0;
    logic                            i_switch_level = 1'b1;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic                            o_step_out;
    logic                            o_dir_out;
    logic [2:0]                      o_status;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [shs_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [shs_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    stepper_homing_sequencer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_start_req    (i_start_req),
        .i_switch_level (i_switch_level),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_step_out     (o_step_out),
        .o_dir_out      (o_dir_out),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // predicted sequencer state
    shs_pkg::t_phase ph;
    logic [19:0]     pulses_done;
    logic [15:0]     half_timer;
    logic            pulse_high;
    logic            pressed;
    logic [15:0]     since_press;
    logic            prev_sw;
    logic [2:0]      status_lvl;
    logic            dir_lvl;

    // predicted register contents
    logic [15:0] fast_half;
    logic [15:0] slow_half;
    logic [19:0] travel_len;
    logic [15:0] backoff_len;
    logic [15:0] debounce_len;
    logic        home_lvl;

    t_pins pins_due[$];

    int  fail_count = 0;
    int  checked = 0;
    int  ticks_sent = 0;
    int  cycle_ticks = 0;
    int  cycles_run = 0;
    int  n_homed = 0;
    int  n_fast_fail = 0;
    int  n_slow_fail = 0;
    bit  quiet = 1'b0;
    logic sw_now = 1'b1;

    function automatic void reset_predictor();
        ph           = shs_pkg::PH_IDLE;
        pulses_done  = '0;
        half_timer   = '0;
        pulse_high   = 1'b0;
        pressed      = 1'b0;
        since_press  = shs_pkg::SINCE_MAX;
        prev_sw      = 1'b1;
        status_lvl   = shs_pkg::ST_NEVER;
        dir_lvl      = 1'b0;
        fast_half    = shs_pkg::RST_FAST_HALF;
        slow_half    = shs_pkg::RST_SLOW_HALF;
        travel_len   = shs_pkg::RST_TRAVEL;
        backoff_len  = shs_pkg::RST_BACKOFF;
        debounce_len = shs_pkg::RST_DEBOUNCE;
        home_lvl     = shs_pkg::RST_HOME_DIR;
    endfunction

    function automatic void apply_reg(input logic [shs_pkg::CFG_INDEX_W-1:0] idx,
                                      input logic [shs_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            shs_pkg::CFG_FAST_HALF: fast_half    = val[15:0];
            shs_pkg::CFG_SLOW_HALF: slow_half    = val[15:0];
            shs_pkg::CFG_TRAVEL:    travel_len   = val;
            shs_pkg::CFG_BACKOFF:   backoff_len  = val[15:0];
            shs_pkg::CFG_DEBOUNCE:  debounce_len = val[15:0];
            shs_pkg::CFG_HOME_DIR:  home_lvl     = val[0];
            default: ;
        endcase
    endfunction

    // a zero half period counts as one tick
    function automatic logic [15:0] half_len();
        logic [15:0] hp;
        hp = (ph == shs_pkg::PH_FAST) ? fast_half : slow_half;
        return (hp == 16'd0) ? 16'd1 : hp;
    endfunction

    // decision before each pulse, phase changes take effect on the same tick
    function automatic void check_point();
        logic [19:0] limit;
        for (int guard = 0; guard < 4 && ph != shs_pkg::PH_IDLE; guard++) begin
            limit = (ph == shs_pkg::PH_FAST) ? travel_len : {4'b0, backoff_len};
            if (!pressed && pulses_done < limit) begin
                pulse_high = 1'b1;
                half_timer = half_len();
                return;
            end
            case (ph)
                shs_pkg::PH_FAST: begin
                    if (pressed) begin
                        pressed     = 1'b0;
                        ph          = shs_pkg::PH_BACK;
                        dir_lvl     = ~home_lvl;
                        pulses_done = '0;
                    end else begin
                        status_lvl = shs_pkg::ST_FAST_FAIL;
                        ph         = shs_pkg::PH_IDLE;
                    end
                end
                shs_pkg::PH_BACK: begin
                    ph          = shs_pkg::PH_SLOW;
                    dir_lvl     = home_lvl;
                    pulses_done = '0;
                end
                default: begin
                    status_lvl = pressed ? shs_pkg::ST_HOMED : shs_pkg::ST_SLOW_FAIL;
                    ph         = shs_pkg::PH_IDLE;
                end
            endcase
        end
    endfunction

    function automatic t_pins advance_tick(input logic start, input logic sw);
        logic fresh;
        logic at_check;
        t_pins res;
        fresh = 1'b0;
        if (ph == shs_pkg::PH_IDLE && start) begin
            ph          = shs_pkg::PH_FAST;
            dir_lvl     = home_lvl;
            pulses_done = '0;
            half_timer  = '0;
            pulse_high  = 1'b0;
            pressed     = 1'b0;
            status_lvl  = shs_pkg::ST_RUNNING;
            fresh       = 1'b1;
        end
        if (since_press != shs_pkg::SINCE_MAX) since_press++;
        // falling edges count only while a cycle runs
        if (ph != shs_pkg::PH_IDLE && prev_sw && !sw
                && (since_press == shs_pkg::SINCE_MAX || since_press > debounce_len)) begin
            pressed     = 1'b1;
            since_press = '0;
        end
        prev_sw = sw;
        if (ph != shs_pkg::PH_IDLE) begin
            at_check = fresh;
            if (!fresh) begin
                if (half_timer != 16'd0) half_timer--;
                if (half_timer == 16'd0) begin
                    if (pulse_high) begin
                        pulse_high = 1'b0;
                        half_timer = half_len();
                    end else begin
                        if (pulses_done != '1) pulses_done++;
                        at_check = 1'b1;
                    end
                end
            end
            if (at_check) check_point();
        end
        if (ph == shs_pkg::PH_IDLE) begin
            pulse_high = 1'b0;
            half_timer = '0;
        end
        res.step   = pulse_high;
        res.dir    = dir_lvl;
        res.status = status_lvl;
        return res;
    endfunction

    task automatic send_tick(input logic start, input logic sw);
        while (!quiet && $urandom_range(99) < 18) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_start_req    <= start;
        i_switch_level <= sw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pins_due.push_back(advance_tick(start, sw));
        ticks_sent++;
    endtask

    task automatic write_reg(input logic [shs_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [shs_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, val);
    endtask

    // wait until every result is in and the block has nothing in flight
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pins_due.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // unused upper data bits are random, plus one write to an unknown index
    task automatic configure(input logic [15:0] fast, input logic [15:0] slow,
                             input logic [19:0] travel, input logic [15:0] backoff,
                             input logic [15:0] debounce, input logic dir);
        logic [shs_pkg::CFG_INDEX_W-1:0] stray;
        settle();
        write_reg(shs_pkg::CFG_FAST_HALF, {4'($urandom), fast});
        write_reg(shs_pkg::CFG_SLOW_HALF, {4'($urandom), slow});
        write_reg(shs_pkg::CFG_TRAVEL, travel);
        write_reg(shs_pkg::CFG_BACKOFF, {4'($urandom), backoff});
        write_reg(shs_pkg::CFG_DEBOUNCE, {4'($urandom), debounce});
        write_reg(shs_pkg::CFG_HOME_DIR, {19'($urandom), dir});
        stray = shs_pkg::CFG_HOME_DIR + 3'd1 + 3'($urandom_range(1));
        write_reg(stray, 20'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // one homing cycle; the switch toggles per tick with a chance set for each phase
    task automatic run_homing(input int fast_pct, input int back_pct,
                              input int slow_pct, input int start_pct);
        int pct;
        send_tick(1'b1, sw_now);
        cycle_ticks++;
        while (ph != shs_pkg::PH_IDLE) begin
            case (ph)
                shs_pkg::PH_FAST: pct = fast_pct;
                shs_pkg::PH_BACK: pct = back_pct;
                default:          pct = slow_pct;
            endcase
            if ($urandom_range(99) < pct) sw_now = ~sw_now;
            send_tick($urandom_range(99) < start_pct, sw_now);
            cycle_ticks++;
        end
        cycles_run++;
        case (status_lvl)
            shs_pkg::ST_HOMED:     n_homed++;
            shs_pkg::ST_FAST_FAIL: n_fast_fail++;
            default:               n_slow_fail++;
        endcase
    endtask

    function automatic logic [15:0] pick_half();
        return ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
    endfunction

    function automatic logic [19:0] pick_count(input int top);
        return ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom_range(1, top));
    endfunction

    task automatic test_idle_after_reset();
        // switch edges while idle are no presses, outputs keep reset levels
        for (int n = 0; n < 4; n++) begin
            sw_now = ~sw_now;
            send_tick(1'b0, sw_now);
        end
    endtask

    task automatic test_directed_cycles();
        // all limits and half periods zero: the fast move fails on its start tick
        configure(16'd0, 16'd0, 20'd0, 16'd0, 16'd0, 1'b0);
        run_homing(0, 0, 0, 0);
        // bouncing all the way, press during back-off ends it: homed
        configure(16'd1, 16'd1, 20'd3, 16'd1, 16'd0, 1'b1);
        run_homing(100, 100, 100, 100);
        // press in the fast move only: the slow approach runs out
        run_homing(100, 0, 0, 0);
        // no press: the rail runs out
        run_homing(0, 0, 0, 0);
    endtask

    task automatic test_random_cycles();
        int base;
        int group;
        base  = cycle_ticks;
        group = 0;
        while (cycle_ticks - base < 700) begin
            quiet = (group >= 4 && group < 9);
            configure(pick_half(), pick_half(), pick_count(12), 16'(pick_count(6)),
                      16'($urandom_range(20)), 1'($urandom_range(1)));
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(3)) begin
                    sw_now = 1'($urandom_range(1));
                    send_tick(1'b0, sw_now);
                end
                run_homing($urandom_range(40), $urandom_range(40),
                           $urandom_range(40), $urandom_range(50));
            end
            group++;
        end
        quiet = 1'b0;
    endtask

    task automatic test_extreme_periods();
        quiet = 1'b1;
        // long half periods, top debounce: only a press after a saturated count is taken
        configure(16'd50, 16'd40, 20'd1, 16'd1, 16'hFFFF, 1'b0);
        run_homing(1, 50, 50, 10);
        // whole rail and longest back-off, each cut short by a press
        configure(16'd1, 16'd1, 20'hFFFFF, 16'hFFFF, 16'd0, 1'b1);
        run_homing(50, 50, 0, 10);
        quiet = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_pins got;
        t_pins want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_step_out, o_dir_out, o_status};
            if (pins_due.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: step %0b dir %0b status %0d",
                             got.step, got.dir, got.status);
            end else begin
                want = pins_due.pop_front();
                checked++;
                if (got.step !== want.step || got.dir !== want.dir
                        || got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch at result %0d: expected step %0b dir %0b %s %0d, %s",
                                 checked, want.step, want.dir, "status", want.status,
                                 $sformatf("got step %0b dir %0b status %0d",
                                           got.step, got.dir, got.status));
                end
            end
        end
        i_out_ready <= quiet || ($urandom_range(99) >= 18);
    end

    initial begin
        reset_predictor();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_after_reset();
        test_directed_cycles();
        test_random_cycles();
        test_extreme_periods();
        settle();
        repeat (8) @(posedge i_clk);
        $display("ran %0d homing cycles: %0d homed, %0d fast failures, %0d slow failures",
                 cycles_run, n_homed, n_fast_fail, n_slow_fail);
        $display("checked %0d result items over %0d ticks, %0d errors",
                 checked, ticks_sent, fail_count);
        if (fail_count == 0 && pins_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #12_000_000;
        $display("timed out with %0d results outstanding", pins_due.size());
        $display("FAIL");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/shs_pkg.sv
src/stepper_homing_sequencer_unit.sv
bench/tb_stepper_homing_sequencer_unit.sv
